@@ sv/gsu_pkg.sv @@
// Shared types, constants and the septet remap function for the GSM septet unpacker.
// No dependencies; imported by gsu_front, gsu_resq and gsm_septet_unpacker.
package gsu_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [6:0] ChAt     = 7'd64;
	localparam logic [6:0] ChDollar = 7'd36;
	localparam logic [6:0] ChSpace  = 7'd32;
	localparam logic [6:0] ChNone   = 7'd0;
	localparam logic [2:0] LastPhase = 3'd6;

	typedef struct packed {
		logic [6:0] ch;
		logic       eom;
		logic       err;
	} result_t;

	// One or two results offered by the front stage to the result queue.
	typedef struct packed {
		logic    valid;
		logic    two;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic [6:0] remap_septet(input logic [6:0] s);
		logic [6:0] r;
		r = s;
		if (s == 7'd0) begin
			r = ChAt;
		end else if (s == 7'd2) begin
			r = ChDollar;
		end else if (s inside {[7'd1:7'd9], 7'd11, 7'd12, [7'd14:7'd31],
				[7'd91:7'd95], [7'd123:7'd127]}) begin
			r = ChSpace;
		end
		return r;
	endfunction

endpackage

@@ sv/gsm_septet_unpacker.sv @@
// GSM 7-bit septet unpacker, top level; depends on gsu_pkg, gsu_front and gsu_resq.
// An accepted word is registered in s1, then written into the result queue that drives the outputs.
// Throughput: one word per cycle while the queue has room for two results. The seventh word of
// each group adds a second result; read out one per cycle, long runs of groups stall the input.
// Reset (arst_n low, asynchronous) empties the queue and returns the leftover bits, group
// phase and start-of-message flag to their initial values.
module gsm_septet_unpacker
	import gsu_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] packed_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] ascii_char,
	output logic       end_of_message,
	output logic       input_error
);

	push_t push;
	logic  take;

	gsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.packed_byte (packed_byte),
		.last_byte   (last_byte),
		.take        (take),
		.push        (push)
	);

	gsu_resq #(
		.DEPTH (QUEUE_DEPTH)
	) u_resq (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.take           (take),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ascii_char     (ascii_char),
		.end_of_message (end_of_message),
		.input_error    (input_error)
	);

	// An error word is always a whole message by itself with no character.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && input_error |-> (ascii_char == ChNone) && end_of_message)
		else $error("error result carries a character or lacks end of message");

	// A two-result word never flags an error and ends the message only on its second result.
	a_two_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.two |-> !push.r0.err && !push.r0.eom && !push.r1.err)
		else $error("malformed two-result word");

	// A word in the front stage that is not taken stays there.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !take |=> push.valid && $stable(push))
		else $error("front stage word lost or changed while stalled");

endmodule

@@ sv/gsu_front.sv @@
// Front stage: holds the leftover bits and group phase, registers each word into s1,
// and forms the one or two remapped results. Depends on gsu_pkg.
module gsu_front
	import gsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] packed_byte,
	input  logic       last_byte,
	input  logic       take,
	output push_t      push
);

	logic [5:0]  leftover_q;
	logic [2:0]  phase_q;
	logic        start_q;

	logic        valid_s1;
	logic [13:0] comb_s1;
	logic        two_s1;
	logic        last_s1;
	logic        err_s1;

	logic        accept;
	logic [2:0]  phase;
	logic [13:0] combined;
	logic        err;

	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;

	assign phase    = (phase_q > LastPhase) ? 3'd0 : phase_q;
	assign combined = {8'd0, leftover_q} | ({6'd0, packed_byte} << phase);
	assign err      = start_q && last_byte && packed_byte[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_q <= '0;
			phase_q    <= '0;
			start_q    <= 1'b1;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (err || last_byte) begin
					leftover_q <= '0;
					phase_q    <= '0;
					start_q    <= 1'b1;
				end else if (phase == LastPhase) begin
					leftover_q <= '0;
					phase_q    <= '0;
					start_q    <= 1'b0;
				end else begin
					leftover_q <= combined[12:7];
					phase_q    <= phase + 3'd1;
					start_q    <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			comb_s1 <= combined;
			two_s1  <= !err && (phase == LastPhase);
			last_s1 <= last_byte;
			err_s1  <= err;
		end
	end

	always_comb begin
		push.valid = valid_s1;
		push.two   = two_s1;
		if (err_s1) begin
			push.r0 = '{ch: ChNone, eom: 1'b1, err: 1'b1};
		end else begin
			push.r0 = '{ch: remap_septet(comb_s1[6:0]), eom: last_s1 && !two_s1, err: 1'b0};
		end
		push.r1 = '{ch: remap_septet(comb_s1[13:7]), eom: last_s1, err: 1'b0};
	end

endmodule

@@ sv/gsu_resq.sv @@
// Result queue: takes one or two results per word from the front stage and
// hands them out one per cycle while out_ready is high. Depends on gsu_pkg.
module gsu_resq
	import gsu_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       take,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] ascii_char,
	output logic       end_of_message,
	output logic       input_error
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntRoom = CntW'(DEPTH - 2);

	result_t         mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	logic [PtrW-1:0] wr_ptr_p1;
	logic [PtrW-1:0] wr_ptr_p2;
	logic [PtrW-1:0] rd_ptr_p1;
	logic            pop;
	logic [CntW-1:0] push_n;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrLast) ? '0 : p + PtrW'(1);
	endfunction

	// A word moves on only when room for two results is free, whatever it carries.
	assign take      = push.valid && (cnt_q <= CntRoom);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign push_n    = take ? (push.two ? CntW'(2) : CntW'(1)) : '0;

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
	assign rd_ptr_p1 = ptr_inc(rd_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= push.two ? wr_ptr_p2 : wr_ptr_p1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_p1;
			end
			cnt_q <= cnt_q + push_n - (pop ? CntW'(1) : CntW'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mem_q[wr_ptr_q] <= push.r0;
			if (push.two) begin
				mem_q[wr_ptr_p1] <= push.r1;
			end
		end
	end

	assign ascii_char     = mem_q[rd_ptr_q].ch;
	assign end_of_message = mem_q[rd_ptr_q].eom;
	assign input_error    = mem_q[rd_ptr_q].err;

endmodule

@@ tb/gsm_septet_unpacker_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gsm_septet_unpacker: packed bytes go in, remapped characters are
// predicted by a scoreboard class and compared in order. Depends on gsu_pkg and the RTL.
module gsm_septet_unpacker_tb;
	import gsu_pkg::*;

	localparam int unsigned WordTarget = 1800;
	localparam int unsigned CalmAfter = 1600;
	localparam int unsigned HoldAfter = 400;
	localparam int unsigned LongHoldCycles = 100;
	localparam int unsigned QuietLimit = 3000;

	class septet_tracker;
		result_t expected_chars[$];
		logic [5:0] spill;
		logic [2:0] phase;
		bit fresh;
		int mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			spill = '0;
			phase = '0;
			fresh = 1'b1;
		endfunction

		function logic [6:0] to_ascii(input logic [6:0] s);
			if (s == 7'd0)
				return ChAt;
			if (s == 7'd2)
				return ChDollar;
			// Remaining control codes other than line feed and carriage return become blanks.
			if (s < 7'd32 && s != 7'd10 && s != 7'd13)
				return ChSpace;
			if ((s >= 7'd91 && s <= 7'd95) || s >= 7'd123)
				return ChSpace;
			return s;
		endfunction

		function void push_char(input logic [6:0] ch, input logic eom, input logic err);
			result_t r;
			r.ch = ch;
			r.eom = eom;
			r.err = err;
			expected_chars.push_back(r);
		endfunction

		function void note_word(input logic [7:0] b, input logic l);
			logic [13:0] bits;
			if (fresh && l && b[7]) begin
				push_char(ChNone, 1'b1, 1'b1);
				restart();
				return;
			end
			bits = (14'(b) << phase) | 14'(spill);
			if (phase == LastPhase) begin
				push_char(to_ascii(bits[6:0]), 1'b0, 1'b0);
				push_char(to_ascii(bits[13:7]), l, 1'b0);
				spill = '0;
				phase = '0;
			end else begin
				push_char(to_ascii(bits[6:0]), l, 1'b0);
				spill = bits[12:7];
				phase = phase + 3'd1;
			end
			if (l)
				restart();
			else
				fresh = 1'b0;
		endfunction

		function void check_char(input logic [6:0] ch, input logic eom, input logic err);
			result_t want;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: ch=%0d eom=%0b err=%0b", ch, eom, err);
				return;
			end
			want = expected_chars.pop_front();
			if (want.ch !== ch || want.eom !== eom || want.err !== err) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected ch=%0d eom=%0b err=%0b, got ch=%0d eom=%0b err=%0b",
						want.ch, want.eom, want.err, ch, eom, err);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] packed_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [6:0] ascii_char;
	logic end_of_message;
	logic input_error;

	septet_tracker sb;
	int unsigned sent_count = 0;
	int unsigned quiet_cycles = 0;
	bit calm = 1'b0;
	bit hold_long = 1'b0;

	gsm_septet_unpacker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.packed_byte(packed_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ascii_char(ascii_char),
		.end_of_message(end_of_message),
		.input_error(input_error)
	);

	always #1 clk = ~clk;

	// Inputs change only at rising edges, so the falling edge sees what the next rising
	// edge will accept.
	always @(negedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_word(packed_byte, last_byte);
		if (arst_n && out_valid && out_ready)
			sb.check_char(ascii_char, end_of_message, input_error);
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QuietLimit);
		$display("[gsm_septet_unpacker] ERROR");
		$finish;
	end

	initial begin : sink
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				out_ready <= 1'b0;
				repeat (LongHoldCycles) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic drive_word(input logic [7:0] b, input logic l);
		in_valid <= 1'b1;
		packed_byte <= b;
		last_byte <= l;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		sent_count++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			drive_word(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	initial begin : stimulus
		logic [7:0] group_bytes[8];
		int unsigned pick;
		int unsigned len;
		bit hold_done;
		sb = new();
		hold_done = 1'b0;
		group_bytes = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h7F, 8'hFF, 8'h02};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone bytes: top bit set gives an error word, top bit clear gives one character.
		drive_word(8'h80, 1'b1);
		drive_word(8'hFF, 1'b1);
		drive_word(8'h00, 1'b1);
		drive_word(8'h7F, 1'b1);
		// A full group whose seventh byte ends the message, then one that runs past it.
		for (int i = 0; i < 7; i++)
			drive_word(group_bytes[i], i == 6);
		for (int i = 0; i < 8; i++)
			drive_word(group_bytes[7 - i], i == 7);
		// Leading byte with its top bit set is fine when more bytes follow.
		drive_word(8'h80, 1'b0);
		drive_word(8'h81, 1'b1);

		while (sent_count < WordTarget) begin
			if (sent_count >= CalmAfter)
				calm = 1'b1;
			if (!hold_done && sent_count >= HoldAfter) begin
				hold_long = 1'b1;
				hold_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 1;
			else if (pick < 20)
				len = 7 * $urandom_range(1, 2);
			else if (pick < 90)
				len = $urandom_range(2, 16);
			else
				len = $urandom_range(17, 48);
			send_message(len);
		end
		in_valid <= 1'b0;

		while (sb.expected_chars.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
			$display("[gsm_septet_unpacker] OK");
		else
			$display("[gsm_septet_unpacker] ERROR");
		$finish;
	end

endmodule
